// ===== sv/eat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eat_pkg
// shared types and constants of the mesh edge adjacency table
// ----------------------------------------------------------------------------
package eat_pkg;

  localparam int unsigned MAX_EDGES     = 4096;
  localparam int unsigned ADDR_W        = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W         = $clog2(MAX_EDGES + 1);
  localparam int unsigned VERTEX_BITS   = 16;
  localparam int unsigned TRIANGLE_BITS = 16;
  localparam int unsigned SEL_W         = 12;
  localparam int unsigned EI_W          = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EDGES);

  typedef logic [VERTEX_BITS-1:0]   vtx_t;
  typedef logic [TRIANGLE_BITS-1:0] tri_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MK_NEW  = 2'd0,
    MK_SAME = 2'd1,
    MK_REV  = 2'd2,
    MK_NONE = 2'd3
  } mk_e;

  typedef enum logic [1:0] {
    SIDE_EMPTY = 2'd0,
    SIDE_ONE   = 2'd1,
    SIDE_AMBIG = 2'd2
  } side_e;

  typedef struct packed {
    vtx_t  start_v;
    vtx_t  end_v;
    vtx_t  fwd_apex;
    vtx_t  rev_apex;
    tri_t  fwd_tri;
    tri_t  rev_tri;
    side_e fwd_st;
    side_e rev_st;
  } entry_t;

  typedef struct packed {
    logic same;
    logic rev;
  } hit_t;

endpackage

// ===== sv/edge_adjacency_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_adjacency_table_core
// mesh edge table: clear, insert directed edge, read entry
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An insert scans the stored entries
// in order through a single registered read port of the entry memory and one
// shared compare unit, one entry per clock, each compared once its registered
// read returns; the first matching entry ends the scan early. A read goes
// through S_RD and S_RDDAT to S_RESP (straight to S_RESP when the entry lies
// beyond the fill count), a clear or the unused command straight to S_RESP,
// from which the result enters the output register. The memory needs no
// clearing pass after reset: only entries below the fill count are ever read.
// A finished result may sit in the output register while the next
// transaction is taken.
// ----------------------------------------------------------------------------
module edge_adjacency_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] start_vertex_i,
  input  logic [15:0] end_vertex_i,
  input  logic [15:0] apex_vertex_i,
  input  logic [15:0] triangle_number_i,
  input  logic [11:0] entry_select_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] edge_index_o,
  output logic [1:0]  match_kind_o,
  output logic        table_full_o,
  output logic [15:0] entry_start_o,
  output logic [15:0] entry_end_o,
  output logic [15:0] forward_apex_o,
  output logic [15:0] reverse_apex_o,
  output logic [15:0] forward_triangle_o,
  output logic [15:0] reverse_triangle_o,
  output logic [1:0]  forward_status_o,
  output logic [1:0]  reverse_status_o
);
  import eat_pkg::*;

  localparam int unsigned CMP_W = CNT_W + SEL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_RDDAT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  typedef struct packed {
    vtx_t             start_v;
    vtx_t             end_v;
    vtx_t             apex;
    tri_t             tri_n;
    logic [SEL_W-1:0] sel;
  } req_t;

  typedef struct packed {
    logic [EI_W-1:0] edge_index;
    mk_e             match_kind;
    logic            table_full;
    entry_t          ent;
  } res_t;

  // triangles are shown only on a side that holds exactly one
  function automatic entry_t view(entry_t e);
    entry_t v;
    v = e;
    if (e.fwd_st != SIDE_ONE) begin
      v.fwd_tri = '0;
    end
    if (e.rev_st != SIDE_ONE) begin
      v.rev_tri = '0;
    end
    return v;
  endfunction

  logic [2:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  addr_t            cmp_idx_q, cmp_idx_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  logic   in_acc, out_free;
  logic   rd_en, wr_en;
  addr_t  rd_addr, wr_addr;
  entry_t wr_data, rd_data, upd_ent, new_ent;
  hit_t   hit;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  eat_mem u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // compare the pending edge against the entry read in the previous cycle
  eat_cmp u_cmp (
    .start_i(req_q.start_v),
    .end_i  (req_q.end_v),
    .apex_i (req_q.apex),
    .tri_i  (req_q.tri_n),
    .entry_i(rd_data),
    .hit_o  (hit),
    .upd_o  (upd_ent)
  );

  // fresh entry appended on a miss, reverse side empty
  always_comb begin
    new_ent          = '0;
    new_ent.start_v  = req_q.start_v;
    new_ent.end_v    = req_q.end_v;
    new_ent.fwd_apex = req_q.apex;
    new_ent.fwd_tri  = req_q.tri_n;
    new_ent.fwd_st   = SIDE_ONE;
    new_ent.rev_st   = SIDE_EMPTY;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    rd_addr     = issue_q[ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_q;
    wr_data     = upd_ent;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d.start_v = start_vertex_i;
          req_d.end_v   = end_vertex_i;
          req_d.apex    = apex_vertex_i;
          req_d.tri_n   = triangle_number_i;
          req_d.sel     = entry_select_i;
          res_d            = '0;
          res_d.match_kind = MK_NONE;
          unique case (cmd_e'(command_i))
            CMD_CLEAR: begin
              count_d = '0;
              state_d = S_RESP;
            end
            CMD_INSERT: begin
              issue_d = '0;
              state_d = S_SCAN;
            end
            CMD_READ: begin
              res_d.edge_index = EI_W'(entry_select_i);
              if (CMP_W'(entry_select_i) < CMP_W'(count_q)) begin
                state_d = S_RD;
              end else begin
                state_d = S_RESP;
              end
            end
            CMD_NOP: begin
              state_d = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // keep one read in flight while the previous entry is compared
        rd_en = (issue_q < count_q);
        if (rd_en) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[ADDR_W-1:0];
          issue_d   = issue_q + 1'b1;
        end
        priority if (cmp_vld_q && (hit.same || hit.rev)) begin
          wr_en            = 1'b1;
          wr_addr          = cmp_idx_q;
          wr_data          = upd_ent;
          res_d.edge_index = EI_W'(cmp_idx_q);
          res_d.match_kind = hit.same ? MK_SAME : MK_REV;
          res_d.table_full = 1'b0;
          res_d.ent        = view(upd_ent);
          cmp_vld_d        = 1'b0;
          state_d          = S_RESP;
        end else if (!rd_en && !cmp_vld_q) begin
          // every stored entry compared without a match
          if (count_q >= CNT_MAX) begin
            res_d            = '0;
            res_d.match_kind = MK_NONE;
            res_d.table_full = 1'b1;
          end else begin
            wr_en            = 1'b1;
            wr_addr          = count_q[ADDR_W-1:0];
            wr_data          = new_ent;
            count_d          = count_q + 1'b1;
            res_d.edge_index = EI_W'(count_q);
            res_d.match_kind = MK_NEW;
            res_d.table_full = 1'b0;
            res_d.ent        = view(new_ent);
          end
          state_d = S_RESP;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(req_q.sel);
        state_d = S_RDDAT;
      end

      S_RDDAT: begin
        res_d.ent = view(rd_data);
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign edge_index_o       = out_q.edge_index;
  assign match_kind_o       = out_q.match_kind;
  assign table_full_o       = out_q.table_full;
  assign entry_start_o      = out_q.ent.start_v;
  assign entry_end_o        = out_q.ent.end_v;
  assign forward_apex_o     = out_q.ent.fwd_apex;
  assign reverse_apex_o     = out_q.ent.rev_apex;
  assign forward_triangle_o = out_q.ent.fwd_tri;
  assign reverse_triangle_o = out_q.ent.rev_tri;
  assign forward_status_o   = out_q.ent.fwd_st;
  assign reverse_status_o   = out_q.ent.rev_st;

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("edge count beyond table size");

  // the entry memory is only written at the end of a scan
  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_SCAN))
    else $error("table write outside scan");

  // full is reported only when the table really is full
  a_full_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_q.table_full) |-> (count_q == CNT_MAX))
    else $error("table full reported below capacity");

  // a compare hit ends the scan at once
  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmp_vld_q && (hit.same || hit.rev)) |=> (state_q == S_RESP))
    else $error("scan continued after a hit");

endmodule

// ===== sv/eat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eat_mem
// edge entry storage, one write and one registered read port
// ----------------------------------------------------------------------------
module eat_mem (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  eat_pkg::addr_t wr_addr_i,
  input  eat_pkg::entry_t wr_data_i,
  input  logic           rd_en_i,
  input  eat_pkg::addr_t rd_addr_i,
  output eat_pkg::entry_t rd_data_o
);
  import eat_pkg::*;

  entry_t mem [MAX_EDGES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/eat_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eat_cmp
// edge compare and side claim unit, shared by every step of the scan
// ----------------------------------------------------------------------------
module eat_cmp (
  input  eat_pkg::vtx_t   start_i,
  input  eat_pkg::vtx_t   end_i,
  input  eat_pkg::vtx_t   apex_i,
  input  eat_pkg::tri_t   tri_i,
  input  eat_pkg::entry_t entry_i,
  output eat_pkg::hit_t   hit_o,
  output eat_pkg::entry_t upd_o
);
  import eat_pkg::*;

  logic same, rev;

  // same direction wins, so a degenerate edge claims the forward side
  assign same = (start_i == entry_i.start_v) && (end_i == entry_i.end_v);
  assign rev  = !same && (start_i == entry_i.end_v) && (end_i == entry_i.start_v);

  assign hit_o = '{same: same, rev: rev};

  always_comb begin
    upd_o = entry_i;
    if (same) begin
      if (entry_i.fwd_st == SIDE_EMPTY) begin
        upd_o.fwd_st  = SIDE_ONE;
        upd_o.fwd_tri = tri_i;
      end else begin
        upd_o.fwd_st = SIDE_AMBIG;
      end
      upd_o.fwd_apex = apex_i;
    end else if (rev) begin
      if (entry_i.rev_st == SIDE_EMPTY) begin
        upd_o.rev_st  = SIDE_ONE;
        upd_o.rev_tri = tri_i;
      end else begin
        upd_o.rev_st = SIDE_AMBIG;
      end
      upd_o.rev_apex = apex_i;
    end
  end

endmodule
